// ===== hw/rtl/assert_macros.svh =====
// assertion helpers used by the rtl top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge outside reset
`define SAOE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// condition that must never hold outside reset
`define SAOE_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

// ===== hw/rtl/saoe_pkg.sv =====
package saoe_pkg;

  // q2.30 unit vector component
  localparam int Q_W      = 32;
  localparam int FRAC_W   = 30;
  // normalised magnitude width and root / quotient width
  localparam int M_W      = 30;
  localparam int R_W      = 31;
  localparam int WORD_W   = 64;

  localparam int SAT_W    = 37;
  localparam int SUN_W    = 29;
  localparam int ECC_W    = 17;
  localparam int SYS_W    = 2;
  localparam int OFF_W    = 18;
  localparam int CROSS_W  = 64;

  // pipeline latencies
  localparam int UNIT_LAT  = 5 + R_W + R_W + 1;
  localparam int CROSS_LAT = 2;
  localparam int FINAL_LAT = 3;
  localparam int PIPE_LAT  = 3 * UNIT_LAT + 2 * CROSS_LAT + FINAL_LAT;

  localparam logic [SYS_W-1:0] SYS_OTHER = 2'd2;
  localparam int OFF_MAX = 131071;

  typedef logic signed [Q_W-1:0] q_t;
  typedef q_t qvec_t [3];

endpackage

// ===== hw/rtl/sat_antenna_offset_to_ecef.sv =====
// Satellite antenna phase-centre offset in ECEF under nominal yaw attitude.
// Input channel: drive the in_ ports and pulse start; a transaction is taken at
// every rising edge with start high and busy low. busy is always low, so one
// transaction may be issued every cycle.
// Result channel: out_valid is high for one cycle with out_off_x/y/z and
// out_degenerate; the receiver must take it then, it cannot hold results off.
// Throughput is one transaction per cycle. The path from start to out_valid
// runs through three unit-vector units in series, each a 68 stage pipeline
// (5 stages of scaling and squares, 31 square root stages, 31 division
// stages and an output stage), two 2 stage cross products and a 3 stage
// multiply, sum and rounding tail.
// Results leave in the order the transactions arrived.
// Reset (rst_n low, synchronous) clears the valid line so no result appears
// until a new transaction has gone through; data in flight is dropped.
`include "assert_macros.svh"

module sat_antenna_offset_to_ecef import saoe_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [SAT_W-1:0] in_sat_x,
  input  logic signed [SAT_W-1:0] in_sat_y,
  input  logic signed [SAT_W-1:0] in_sat_z,
  input  logic signed [SUN_W-1:0] in_sun_x,
  input  logic signed [SUN_W-1:0] in_sun_y,
  input  logic signed [SUN_W-1:0] in_sun_z,
  input  logic signed [ECC_W-1:0] in_ecc_toward_earth,
  input  logic signed [ECC_W-1:0] in_ecc_panel_axis,
  input  logic signed [ECC_W-1:0] in_ecc_sun_side,
  input  logic [SYS_W-1:0]        in_sat_system,
  output logic                    out_valid,
  output logic signed [OFF_W-1:0] out_off_x,
  output logic signed [OFF_W-1:0] out_off_y,
  output logic signed [OFF_W-1:0] out_off_z,
  output logic                    out_degenerate
);

  localparam int VEC_W  = 3 * Q_W;
  localparam int SIDE_W = 3 * ECC_W + SYS_W;
  localparam int PROD_W = ECC_W + Q_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int RND_W  = SUM_W - FRAC_W;

  assign busy = 1'b0;

  // valid line
  logic [PIPE_LAT-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[PIPE_LAT-2:0], start && !busy};
    end
  end

  // unit satellite and sun vectors
  logic signed [SAT_W-1:0] sat_v [3];
  logic signed [SUN_W-1:0] sun_v [3];
  qvec_t su;
  qvec_t sn;
  qvec_t rk;
  logic  su_nz;
  logic  sn_nz;

  assign sat_v = '{in_sat_x, in_sat_y, in_sat_z};
  assign sun_v = '{in_sun_x, in_sun_y, in_sun_z};

  saoe_unit #(.IN_W(SAT_W)) u_sat_unit (
    .clk(clk), .in_v(sat_v), .out_u(su), .out_nz(su_nz)
  );

  saoe_unit #(.IN_W(SUN_W)) u_sun_unit (
    .clk(clk), .in_v(sun_v), .out_u(sn), .out_nz(sn_nz)
  );

  // earth direction is the negated satellite direction
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rk[i] = -su[i];
    end
  end

  // panel axis
  logic signed [CROSS_W-1:0] cj [3];
  qvec_t rj;
  logic  rj_nz;

  saoe_cross u_cross_j (.clk(clk), .in_a(rk), .in_b(sn), .out_c(cj));

  saoe_unit #(.IN_W(CROSS_W)) u_rj_unit (
    .clk(clk), .in_v(cj), .out_u(rj), .out_nz(rj_nz)
  );

  // earth direction held until the panel axis is ready
  logic [VEC_W-1:0] rk_d1;
  qvec_t            rk_a;

  saoe_delay #(.WIDTH(VEC_W), .DEPTH(CROSS_LAT + UNIT_LAT)) u_rk_dly1 (
    .clk(clk), .din({rk[0], rk[1], rk[2]}), .dout(rk_d1)
  );

  assign rk_a = '{q_t'(rk_d1[3*Q_W-1:2*Q_W]), q_t'(rk_d1[2*Q_W-1:Q_W]),
                  q_t'(rk_d1[Q_W-1:0])};

  // sun-side axis
  logic signed [CROSS_W-1:0] ci [3];
  qvec_t ri;
  logic  ri_nz;

  saoe_cross u_cross_i (.clk(clk), .in_a(rj), .in_b(rk_a), .out_c(ci));

  saoe_unit #(.IN_W(CROSS_W)) u_ri_unit (
    .clk(clk), .in_v(ci), .out_u(ri), .out_nz(ri_nz)
  );

  // align the other two axes and the panel flag with the sun-side axis
  logic [VEC_W-1:0] rk_d2;
  logic [VEC_W:0]   rj_d;

  saoe_delay #(.WIDTH(VEC_W), .DEPTH(CROSS_LAT + UNIT_LAT)) u_rk_dly2 (
    .clk(clk), .din(rk_d1), .dout(rk_d2)
  );

  saoe_delay #(.WIDTH(VEC_W + 1), .DEPTH(CROSS_LAT + UNIT_LAT)) u_rj_dly (
    .clk(clk), .din({rj_nz, rj[0], rj[1], rj[2]}), .dout(rj_d)
  );

  // eccentricity and system follow the geometry
  logic [SIDE_W-1:0] side_d;

  saoe_delay #(.WIDTH(SIDE_W), .DEPTH(PIPE_LAT - FINAL_LAT)) u_side_dly (
    .clk(clk),
    .din({in_ecc_sun_side, in_ecc_panel_axis, in_ecc_toward_earth, in_sat_system}),
    .dout(side_d)
  );

  logic signed [ECC_W-1:0] ecc_d [3];
  qvec_t                   axis [3];
  logic                    ok;

  always_comb begin
    ecc_d[0] = side_d[SIDE_W-1 -: ECC_W];
    ecc_d[1] = side_d[SIDE_W-1-ECC_W -: ECC_W];
    ecc_d[2] = side_d[SIDE_W-1-2*ECC_W -: ECC_W];
    axis[0]  = ri;
    for (int i = 0; i < 3; i++) begin
      axis[1][i] = q_t'(rj_d[(3-i)*Q_W-1 -: Q_W]);
      axis[2][i] = q_t'(rk_d2[(3-i)*Q_W-1 -: Q_W]);
    end
    ok = rj_d[VEC_W] && ri_nz;
  end

  // tail stage 1: weighted axis components
  logic signed [PROD_W-1:0] prod_r [3][3];
  logic                     ok1_r;
  logic [SYS_W-1:0]         sys1_r;

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      for (int c = 0; c < 3; c++) begin
        prod_r[a][c] <= PROD_W'(ecc_d[a]) * PROD_W'(axis[a][c]);
      end
    end
    ok1_r  <= ok;
    sys1_r <= side_d[SYS_W-1:0];
  end

  // tail stage 2: sum per ecef axis
  logic signed [SUM_W-1:0] sum_r [3];
  logic                    ok2_r;
  logic [SYS_W-1:0]        sys2_r;

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      sum_r[c] <= SUM_W'(prod_r[0][c]) + SUM_W'(prod_r[1][c]) + SUM_W'(prod_r[2][c]);
    end
    ok2_r  <= ok1_r;
    sys2_r <= sys1_r;
  end

  // tail stage 3: round half up, saturate, gate
  logic signed [SUM_W-1:0] biased [3];
  logic signed [RND_W-1:0] rnd    [3];
  logic signed [OFF_W-1:0] off_nxt [3];
  logic signed [OFF_W-1:0] off_r  [3];
  logic                    deg_r;
  logic [SYS_W-1:0]        sys3_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      biased[c] = sum_r[c] + (SUM_W'(1) <<< (FRAC_W - 1));
      rnd[c]    = RND_W'(biased[c] >>> FRAC_W);
      if (!ok2_r || sys2_r >= SYS_OTHER) begin
        off_nxt[c] = '0;
      end else if (rnd[c] > RND_W'(OFF_MAX)) begin
        off_nxt[c] = OFF_W'(OFF_MAX);
      end else if (rnd[c] < -RND_W'(OFF_MAX)) begin
        off_nxt[c] = -OFF_W'(OFF_MAX);
      end else begin
        off_nxt[c] = OFF_W'(rnd[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    off_r  <= off_nxt;
    deg_r  <= !ok2_r;
    sys3_r <= sys2_r;
  end

  assign out_valid      = vld_r[PIPE_LAT-1];
  assign out_off_x      = off_r[0];
  assign out_off_y      = off_r[1];
  assign out_off_z      = off_r[2];
  assign out_degenerate = deg_r;

  // checks
  `SAOE_ASSERT_IMPLY(a_deg_zero, clk, rst_n, out_valid && out_degenerate,
    out_off_x == 0 && out_off_y == 0 && out_off_z == 0)
  `SAOE_ASSERT_IMPLY(a_other_zero, clk, rst_n, out_valid && sys3_r >= SYS_OTHER,
    out_off_x == 0 && out_off_y == 0 && out_off_z == 0)
  `SAOE_ASSERT_IMPLY(a_latency, clk, rst_n, out_valid, $past(start && !busy, PIPE_LAT))
  `SAOE_ASSERT_NEVER(a_sat_range, clk, rst_n,
    out_valid && (out_off_x == -OFF_W'(OFF_MAX + 1) || out_off_y == -OFF_W'(OFF_MAX + 1) ||
    out_off_z == -OFF_W'(OFF_MAX + 1)))
  `SAOE_ASSERT_IMPLY(a_sat_unit_zero, clk, rst_n, !su_nz,
    su[0] == 0 && su[1] == 0 && su[2] == 0)
  `SAOE_ASSERT_IMPLY(a_sun_unit_zero, clk, rst_n, !sn_nz,
    sn[0] == 0 && sn[1] == 0 && sn[2] == 0)

endmodule

// ===== hw/rtl/saoe_delay.sv =====
module saoe_delay import saoe_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] sr_r [DEPTH];

  // plain shift line, no reset on payload
  always_ff @(posedge clk) begin
    sr_r[0] <= din;
    for (int i = 1; i < DEPTH; i++) begin
      sr_r[i] <= sr_r[i-1];
    end
  end

  assign dout = sr_r[DEPTH-1];

endmodule

// ===== hw/rtl/saoe_unit.sv =====
module saoe_unit import saoe_pkg::*; #(
  parameter int IN_W = 37
) (
  input  logic                   clk,
  input  logic signed [IN_W-1:0] in_v [3],
  output qvec_t                  out_u,
  output logic                   out_nz
);

  localparam int PW = $clog2(IN_W);

  typedef struct packed {
    logic [2:0][M_W-1:0] m;
    logic [2:0]          neg;
    logic                nz;
  } ucarry_t;

  // stage 1: magnitudes and signs
  logic [IN_W-1:0] mag1_r [3];
  logic [2:0]      neg1_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      neg1_r[i] <= in_v[i][IN_W-1];
      mag1_r[i] <= in_v[i][IN_W-1] ? IN_W'(-in_v[i]) : IN_W'(in_v[i]);
    end
  end

  // stage 2: leading one of the largest magnitude
  logic [IN_W-1:0] any_mag;
  logic [PW-1:0]   pos_nxt;
  logic [PW-1:0]   pos2_r;
  logic [IN_W-1:0] mag2_r [3];
  logic [2:0]      neg2_r;
  logic            nz2_r;

  always_comb begin
    any_mag = mag1_r[0] | mag1_r[1] | mag1_r[2];
    pos_nxt = '0;
    for (int j = 0; j < IN_W; j++) begin
      if (any_mag[j]) pos_nxt = PW'(j);
    end
  end

  always_ff @(posedge clk) begin
    pos2_r <= pos_nxt;
    mag2_r <= mag1_r;
    neg2_r <= neg1_r;
    nz2_r  <= |any_mag;
  end

  // stage 3: common shift to put the top bit at bit 29
  logic [IN_W+M_W-1:0] wide [3];
  ucarry_t             c3_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (pos2_r > PW'(M_W-1)) begin
        wide[i] = {{M_W{1'b0}}, mag2_r[i]} >> (pos2_r - PW'(M_W-1));
      end else begin
        wide[i] = {{M_W{1'b0}}, mag2_r[i]} << (PW'(M_W-1) - pos2_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      c3_r.m[i] <= wide[i][M_W-1:0];
    end
    c3_r.neg <= neg2_r;
    c3_r.nz  <= nz2_r;
  end

  // stage 4: squares
  logic [2*M_W-1:0] sq4_r [3];
  ucarry_t          c4_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq4_r[i] <= (2*M_W)'(c3_r.m[i]) * (2*M_W)'(c3_r.m[i]);
    end
    c4_r <= c3_r;
  end

  // stage 5: sum of squares
  logic [WORD_W-1:0] sum5_r;
  ucarry_t           c5_r;

  always_ff @(posedge clk) begin
    sum5_r <= WORD_W'(sq4_r[0]) + WORD_W'(sq4_r[1]) + WORD_W'(sq4_r[2]);
    c5_r   <= c4_r;
  end

  // square root, one result bit per stage
  logic [WORD_W-1:0] srem_r  [R_W];
  logic [R_W-1:0]    sroot_r [R_W];
  ucarry_t           sc_r    [R_W];

  for (genvar j = 0; j < R_W; j++) begin : g_sqrt
    localparam int K = R_W - 1 - j;
    logic [WORD_W-1:0] rem_in;
    logic [R_W-1:0]    root_in;
    ucarry_t           c_in;
    logic [WORD_W-1:0] trial;
    logic [WORD_W-1:0] rem_nxt;
    logic [R_W-1:0]    root_nxt;

    if (j == 0) begin : g_first
      assign rem_in  = sum5_r;
      assign root_in = '0;
      assign c_in    = c5_r;
    end else begin : g_next
      assign rem_in  = srem_r[j-1];
      assign root_in = sroot_r[j-1];
      assign c_in    = sc_r[j-1];
    end

    always_comb begin
      trial = (WORD_W'(root_in) << (K + 1)) | (WORD_W'(1) << (2 * K));
      if (rem_in >= trial) begin
        rem_nxt  = rem_in - trial;
        root_nxt = root_in | (R_W'(1) << K);
      end else begin
        rem_nxt  = rem_in;
        root_nxt = root_in;
      end
    end

    always_ff @(posedge clk) begin
      srem_r[j]  <= rem_nxt;
      sroot_r[j] <= root_nxt;
      sc_r[j]    <= c_in;
    end
  end

  // restoring division of each magnitude by the norm, one quotient bit per stage
  logic [WORD_W-1:0] drem_r [R_W][3];
  logic [R_W-1:0]    dq_r   [R_W][3];
  logic [R_W-1:0]    dn_r   [R_W];
  ucarry_t           dc_r   [R_W];

  for (genvar j = 0; j < R_W; j++) begin : g_div
    localparam int K = R_W - 1 - j;
    logic [WORD_W-1:0] rem_in  [3];
    logic [R_W-1:0]    q_in    [3];
    logic [R_W-1:0]    n_in;
    ucarry_t           c_in;
    logic [WORD_W-1:0] dv;
    logic [WORD_W-1:0] rem_nxt [3];
    logic [R_W-1:0]    q_nxt   [3];

    if (j == 0) begin : g_first
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          rem_in[i] = WORD_W'(sc_r[R_W-1].m[i]) << FRAC_W;
          q_in[i]   = '0;
        end
      end
      assign n_in = sroot_r[R_W-1];
      assign c_in = sc_r[R_W-1];
    end else begin : g_next
      assign rem_in = drem_r[j-1];
      assign q_in   = dq_r[j-1];
      assign n_in   = dn_r[j-1];
      assign c_in   = dc_r[j-1];
    end

    always_comb begin
      dv = WORD_W'(n_in) << K;
      for (int i = 0; i < 3; i++) begin
        if (rem_in[i] >= dv) begin
          rem_nxt[i] = rem_in[i] - dv;
          q_nxt[i]   = q_in[i] | (R_W'(1) << K);
        end else begin
          rem_nxt[i] = rem_in[i];
          q_nxt[i]   = q_in[i];
        end
      end
    end

    always_ff @(posedge clk) begin
      drem_r[j] <= rem_nxt;
      dq_r[j]   <= q_nxt;
      dn_r[j]   <= n_in;
      dc_r[j]   <= c_in;
    end
  end

  // sign restore, zero vector gives zero
  qvec_t u_r;
  logic  nz_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (!dc_r[R_W-1].nz) begin
        u_r[i] <= '0;
      end else if (dc_r[R_W-1].neg[i]) begin
        u_r[i] <= -Q_W'(dq_r[R_W-1][i]);
      end else begin
        u_r[i] <= Q_W'(dq_r[R_W-1][i]);
      end
    end
    nz_r <= dc_r[R_W-1].nz;
  end

  assign out_u  = u_r;
  assign out_nz = nz_r;

endmodule

// ===== hw/rtl/saoe_cross.sv =====
module saoe_cross import saoe_pkg::*; (
  input  logic                      clk,
  input  qvec_t                     in_a,
  input  qvec_t                     in_b,
  output logic signed [CROSS_W-1:0] out_c [3]
);

  logic signed [CROSS_W-1:0] p_r [6];
  logic signed [CROSS_W-1:0] c_r [3];

  // partial products
  always_ff @(posedge clk) begin
    p_r[0] <= CROSS_W'(in_a[1]) * CROSS_W'(in_b[2]);
    p_r[1] <= CROSS_W'(in_a[2]) * CROSS_W'(in_b[1]);
    p_r[2] <= CROSS_W'(in_a[2]) * CROSS_W'(in_b[0]);
    p_r[3] <= CROSS_W'(in_a[0]) * CROSS_W'(in_b[2]);
    p_r[4] <= CROSS_W'(in_a[0]) * CROSS_W'(in_b[1]);
    p_r[5] <= CROSS_W'(in_a[1]) * CROSS_W'(in_b[0]);
  end

  // differences
  always_ff @(posedge clk) begin
    c_r[0] <= p_r[0] - p_r[1];
    c_r[1] <= p_r[2] - p_r[3];
    c_r[2] <= p_r[4] - p_r[5];
  end

  assign out_c = c_r;

endmodule
